### design/rhht_pkg.sv
// Shared types and constants for the Robin Hood hash table.
`timescale 1ns / 1ps
package rhht_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [31:0] MM_C1      = 32'hCC9E2D51;
    localparam logic [31:0] MM_C2      = 32'h1B873593;
    localparam logic [31:0] MM_N       = 32'hE6546B64;
    localparam logic [31:0] MM_F1      = 32'h85EBCA6B;
    localparam logic [31:0] MM_F2      = 32'hC2B2AE35;
    localparam logic [31:0] SEED_RESET = 32'hB23D66D5;
    localparam logic [31:0] KEY_LEN    = 32'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key_in;
        logic [31:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [9:0]  slot_index;
        logic [10:0] entry_count;
    } out_item_t;

endpackage

### design/rhht_front.sv
// Front end: accepts items, hashes the key and reduces it to a home slot.
`timescale 1ns / 1ps
module rhht_front import rhht_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int IW    = 10,
    parameter int QW    = 66 + 32 + 10
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    seed,
    input  logic           blocked,
    input  logic           in_valid,
    output logic           in_stall,
    input  in_item_t       in_item,
    output logic           q_push,
    output logic [QW-1:0]  q_data,
    input  logic           q_full
);

    localparam logic [IW:0] SLOTS_W = (IW+1)'(SLOTS);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} fstate_t;

    fstate_t        state_reg;
    logic [2:0]     step_reg;
    in_item_t       item_reg;
    logic [31:0]    h_reg, h_next;
    logic [IW-1:0]  rem_reg, rem_next;

    // one murmur step per cycle; steps 0, 1, 3 and 4 hold one multiply each
    always_comb
    begin
        logic [31:0] t;
        t = 32'd0;
        case (step_reg)
            3'd0: h_next = item_reg.key_in * MM_C1;
            3'd1: h_next = {h_reg[16:0], h_reg[31:17]} * MM_C2;
            3'd2:
            begin
                t = seed ^ h_reg;
                t = {t[18:0], t[31:19]};
                h_next = ((t << 2) + t + MM_N) ^ KEY_LEN;
            end
            3'd3: h_next = (h_reg ^ (h_reg >> 16)) * MM_F1;
            3'd4: h_next = (h_reg ^ (h_reg >> 13)) * MM_F2;
            default:
            begin
                t = h_reg ^ (h_reg >> 16);
                h_next = (t == 32'd0) ? 32'd1 : t;
            end
        endcase
    end

    // remainder by SLOTS, four hash bits per cycle, MSB first
    always_comb
    begin
        logic [IW-1:0] r;
        logic [IW:0]   t;
        logic [4:0]    bi;
        r = rem_reg;
        t = '0;
        bi = '0;
        for (int s = 0; s < 4; s++)
        begin
            bi = 5'(5'd31 - {step_reg, 2'b00} - 5'(s));
            t = {r, h_reg[bi]};
            if (t >= SLOTS_W)
                t = t - SLOTS_W;
            r = t[IW-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        item_reg  <= in_item;
                        step_reg  <= '0;
                        state_reg <= F_HASH;
                    end
                F_HASH:
                begin
                    h_reg <= h_next;
                    if (step_reg == 3'd5)
                    begin
                        step_reg  <= '0;
                        rem_reg   <= '0;
                        state_reg <= F_MOD;
                    end
                    else
                        step_reg <= step_reg + 3'd1;
                end
                F_MOD:
                begin
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd7)
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                    if (!q_full)
                        state_reg <= F_IDLE;
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign in_stall = (state_reg != F_IDLE) || blocked;
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_data   = {item_reg, h_reg, rem_reg};

endmodule

### design/rhht_queue.sv
// Two-entry queue between the hashing front end and the probe engine.
`timescale 1ns / 1ps
module rhht_queue import rhht_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [W-1:0]  wdata,
    output logic          full,
    input  logic          pop,
    output logic [W-1:0]  rdata,
    output logic          empty
);

    logic [W-1:0] mem_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign rdata = mem_reg[rp_reg];
    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd3) && ((wp_reg == rp_reg) == (cnt_reg != 2'd1)))
        else $error("queue pointers and count disagree");

endmodule

### design/rhht_back.sv
// Probe engine: slot memories, insert, lookup and backward-shift remove.
`timescale 1ns / 1ps
module rhht_back import rhht_pkg::*;
#(
    parameter int SLOTS = 1024,
    parameter int IW    = 10,
    parameter int QW    = 66 + 32 + 10
)
(
    input  logic           clk,
    input  logic           rst_n,
    output logic           clearing,
    input  logic           q_empty,
    input  logic [QW-1:0]  q_data,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output out_item_t      out_item
);

    localparam logic [IW:0]   SLOTS_W = (IW+1)'(SLOTS);
    localparam logic [IW:0]   LAST_W  = (IW+1)'(SLOTS - 1);
    localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_READ, B_EVAL, B_SHREAD, B_SHEVAL, B_SHEND, B_DONE
    } bstate_t;

    typedef struct packed {
        logic [31:0]   hash;
        logic [IW-1:0] home;
    } hent_t;

    hent_t         hmem [SLOTS];
    logic [63:0]   kvmem [SLOTS];
    hent_t         hrd_reg;
    logic [63:0]   kvrd_reg;

    bstate_t       state_reg;
    logic [IW-1:0] idx_reg, clr_reg;
    logic [IW:0]   dist_reg, n_reg, cnt_reg;
    logic [1:0]    mode_reg, status_reg;
    logic [31:0]   ck_reg, cv_reg, ch_reg, vout_reg;
    logic [IW-1:0] chome_reg, slot_reg;
    logic          placed_reg, out_valid_reg;
    out_item_t     out_reg;

    in_item_t      q_item;
    logic [31:0]   q_hash;
    logic [IW-1:0] q_home;

    logic          rd_en, hwe, kvwe;
    logic [IW-1:0] rd_addr, waddr, idx_inc;
    hent_t         hwdata;
    logic [63:0]   kvwdata;
    logic [IW:0]   d;

    assign {q_item, q_hash, q_home} = q_data;
    assign idx_inc = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;

    // probe distance of the entry just read at idx_reg
    assign d = (idx_reg >= hrd_reg.home) ? {1'b0, idx_reg - hrd_reg.home}
             : ({1'b0, idx_reg} + SLOTS_W - {1'b0, hrd_reg.home});

    // memory control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        hwe     = 1'b0;
        kvwe    = 1'b0;
        waddr   = idx_reg;
        hwdata  = '{hash: ch_reg, home: chome_reg};
        kvwdata = {ck_reg, cv_reg};
        unique case (state_reg)
            B_CLEAR:
            begin
                hwe    = 1'b1;
                waddr  = clr_reg;
                hwdata = '0;
            end
            B_READ:
                rd_en = 1'b1;
            B_EVAL:
                if (mode_reg == MODE_INSERT &&
                    (hrd_reg.hash == 32'd0 || d < dist_reg))
                begin
                    hwe  = 1'b1;
                    kvwe = 1'b1;
                end
            B_SHREAD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc;
            end
            B_SHEVAL:
                if (hrd_reg.hash != 32'd0 && hrd_reg.home != idx_inc)
                begin
                    hwe     = 1'b1;
                    kvwe    = 1'b1;
                    hwdata  = hrd_reg;
                    kvwdata = kvrd_reg;
                end
            B_SHEND:
            begin
                hwe    = 1'b1;
                hwdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
            hmem[waddr] <= hwdata;
        if (kvwe)
            kvmem[waddr] <= kvwdata;
        if (rd_en)
        begin
            hrd_reg  <= hmem[rd_addr];
            kvrd_reg <= kvmem[rd_addr];
        end
    end

    assign q_pop = (state_reg == B_IDLE) && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != B_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST)
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                    if (!q_empty)
                    begin
                        mode_reg   <= q_item.mode;
                        ck_reg     <= q_item.key_in;
                        cv_reg     <= q_item.value_in;
                        ch_reg     <= q_hash;
                        chome_reg  <= q_home;
                        idx_reg    <= q_home;
                        dist_reg   <= '0;
                        n_reg      <= '0;
                        placed_reg <= 1'b0;
                        vout_reg   <= '0;
                        slot_reg   <= '0;
                        if (q_item.mode == MODE_INSERT && cnt_reg >= SLOTS_W)
                        begin
                            status_reg <= ST_FULL;
                            state_reg  <= B_DONE;
                        end
                        else if (q_item.mode == MODE_INSERT ||
                                 q_item.mode == MODE_LOOKUP ||
                                 q_item.mode == MODE_REMOVE)
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= B_READ;
                        end
                        else
                        begin
                            status_reg <= ST_NOTFOUND;
                            state_reg  <= B_DONE;
                        end
                    end
                B_READ:
                    state_reg <= B_EVAL;
                B_EVAL:
                    if (mode_reg == MODE_INSERT)
                    begin
                        status_reg <= ST_OK;
                        if (hrd_reg.hash == 32'd0)
                        begin
                            if (!placed_reg)
                                slot_reg <= idx_reg;
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= B_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            n_reg     <= n_reg + 1'b1;
                            state_reg <= (n_reg == LAST_W) ? B_DONE : B_READ;
                            if (d < dist_reg)
                            begin
                                // swap: carry the displaced resident onward
                                {ck_reg, cv_reg} <= kvrd_reg;
                                ch_reg     <= hrd_reg.hash;
                                chome_reg  <= hrd_reg.home;
                                dist_reg   <= d + 1'b1;
                                placed_reg <= 1'b1;
                                if (!placed_reg)
                                    slot_reg <= idx_reg;
                            end
                            else
                                dist_reg <= dist_reg + 1'b1;
                        end
                    end
                    else if (hrd_reg.hash == 32'd0 || dist_reg > d)
                        state_reg <= B_DONE;
                    else if (hrd_reg.hash == ch_reg && kvrd_reg[63:32] == ck_reg)
                    begin
                        status_reg <= ST_OK;
                        slot_reg   <= idx_reg;
                        n_reg      <= '0;
                        if (mode_reg == MODE_LOOKUP)
                        begin
                            vout_reg  <= kvrd_reg[31:0];
                            state_reg <= B_DONE;
                        end
                        else
                            state_reg <= B_SHREAD;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        n_reg     <= n_reg + 1'b1;
                        dist_reg  <= dist_reg + 1'b1;
                        state_reg <= (n_reg == LAST_W) ? B_DONE : B_READ;
                    end
                B_SHREAD:
                    state_reg <= (n_reg < LAST_W) ? B_SHEVAL : B_SHEND;
                B_SHEVAL:
                    if (hrd_reg.hash == 32'd0 || hrd_reg.home == idx_inc)
                        state_reg <= B_SHEND;
                    else
                    begin
                        idx_reg   <= idx_inc;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= B_SHREAD;
                    end
                B_SHEND:
                begin
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - 1'b1;
                    state_reg <= B_DONE;
                end
                B_DONE:
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.status      <= status_reg;
                        out_reg.value_out   <= vout_reg;
                        out_reg.slot_index  <= 10'(slot_reg);
                        out_reg.entry_count <= 11'(cnt_reg);
                        state_reg           <= B_IDLE;
                    end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= SLOTS_W)
        else $error("entry count above table size");
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EVAL) |-> $past(state_reg == B_READ))
        else $error("evaluate without a read");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_READ) |-> (n_reg < SLOTS_W))
        else $error("probe walk past table size");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("item taken during clearing pass");

endmodule

### design/robin_hood_hash_table.sv
// Top level of the Robin Hood hash table with murmur3 key hashing.
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  --------------------------------
//  in        in   in_valid / in_stall  in_item  (mode, key_in, value_in)
//  out       out  out_valid/out_stall  out_item (status, value_out,
//                                                slot_index, entry_count)
//  cfg       in   cfg_we               cfg_wdata (hash_seed)
//
// The front end takes an item, computes the murmur3 hash (at most one
// multiply per cycle), reduces it by SLOTS (four bits a cycle) and then
// pushes it into the queue.
// The back end reads each probed slot from registered memory, then
// evaluates/writes it; it also takes the item and loads the result. A remove
// adds a read and an evaluate per shifted entry and a clearing write to end it.
// After reset a clearing pass zeroes the hash store; in_stall
// stays high meanwhile. A two-item queue lets the front hash the next item
// while the back probes; one output register holds the result under stall.
`timescale 1ns / 1ps
module robin_hood_hash_table import rhht_pkg::*;
#(
    parameter int SLOTS = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = $bits(in_item_t) + 32 + IW;

    logic [31:0]   seed_reg;
    logic          clearing;
    logic          q_push, q_pop, q_full, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    // hash seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= SEED_RESET;
        else if (cfg_we)
            seed_reg <= cfg_wdata;
    end

    rhht_front #(.SLOTS(SLOTS), .IW(IW), .QW(QW)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (seed_reg),
        .blocked  (clearing),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    rhht_queue #(.W(QW)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    rhht_back #(.SLOTS(SLOTS), .IW(IW), .QW(QW)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
